[sv/dbps_pkg.sv]
package dbps_pkg;

  localparam int AXIS_W = 16;
  localparam int CEN_W = 20;
  localparam int PMS_W = 16;
  localparam int TOT_W = 20;
  localparam int DIST_W = 16;
  localparam int STREAK_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  // projection: Q12.8 times Q1.14, rounded back to 1/256 px
  localparam int PROD_W = CEN_W + AXIS_W + 1;
  localparam int SUM_W = PROD_W + 1;
  localparam int FRAC_W = 14;
  localparam int POS_W = SUM_W - FRAC_W;

  localparam int CONFIRM_FRAMES_DEF = 3;
  localparam logic [DIST_W-1:0] MIN_DETECT = 16'd13;

  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORTH_PULSE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORTH_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NORTH_TARGET = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_PULSE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_MOVE = 3'd7;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NORTH_TIMEOUT = 2'd1;
  localparam logic [1:0] STATUS_SOUTH_TIMEOUT = 2'd2;

  typedef struct packed {
    logic signed [AXIS_W-1:0] dec_axis_x;
    logic signed [AXIS_W-1:0] dec_axis_y;
    logic [PMS_W-1:0] north_pulse_ms;
    logic [TOT_W-1:0] north_limit_ms;
    logic [DIST_W-1:0] north_target;
    logic [PMS_W-1:0] probe_pulse_ms;
    logic [TOT_W-1:0] probe_limit_ms;
    logic [DIST_W-1:0] detect_move;
  } cfg_t;

  typedef struct packed {
    logic cmd;
    logic signed [POS_W-1:0] pos;
  } frame_t;

  typedef struct packed {
    logic pulse_valid;
    logic pulse_dir;
    logic [PMS_W-1:0] pulse_ms;
    logic done_res;
    logic [1:0] status;
    logic [TOT_W-1:0] backlash_ms;
  } res_t;

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                               input logic [PMS_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {{(TOT_W + 1 - PMS_W){1'b0}}, b};
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

endpackage

[sv/dbps_proj.sv]
module dbps_proj (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic cmd,
  input  logic [dbps_pkg::CEN_W-1:0] centroid_x,
  input  logic [dbps_pkg::CEN_W-1:0] centroid_y,
  input  logic signed [dbps_pkg::AXIS_W-1:0] axis_x,
  input  logic signed [dbps_pkg::AXIS_W-1:0] axis_y,
  output logic frame_valid,
  input  logic frame_ready,
  output dbps_pkg::frame_t frame
);
  import dbps_pkg::*;

  logic mul_valid;
  logic mul_cmd;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic mul_ready;
  logic signed [SUM_W-1:0] sum;

  assign mul_ready = !frame_valid || frame_ready;
  assign in_ready = !mul_valid || mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (in_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mul_cmd <= cmd;
      prod_x <= $signed({1'b0, centroid_x}) * axis_x;
      prod_y <= $signed({1'b0, centroid_y}) * axis_y;
    end
  end

  // half up: add half an lsb, then floor shift
  assign sum = {prod_x[PROD_W-1], prod_x} + {prod_y[PROD_W-1], prod_y}
             + $signed(SUM_W'(1) <<< (FRAC_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (mul_ready) begin
      frame_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && mul_valid) begin
      frame.cmd <= mul_cmd;
      frame.pos <= sum[SUM_W-1:FRAC_W];
    end
  end

endmodule

[sv/dbps_ctrl.sv]
module dbps_ctrl #(
  parameter int CONFIRM_FRAMES = dbps_pkg::CONFIRM_FRAMES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  dbps_pkg::cfg_t cfg,
  input  logic frame_valid,
  output logic frame_ready,
  input  dbps_pkg::frame_t frame,
  output logic out_valid,
  input  logic out_stall,
  output dbps_pkg::res_t res
);
  import dbps_pkg::*;

  localparam int DIFF_W = POS_W + 1;
  localparam logic [1:0] STAGE_NORTH = 2'd0;
  localparam logic [1:0] STAGE_SOUTH = 2'd1;
  localparam logic [1:0] STAGE_DONE = 2'd2;
  localparam logic [STREAK_W-1:0] STREAK_MAX = {STREAK_W{1'b1}};
  localparam logic [STREAK_W-1:0] CONFIRM = STREAK_W'(CONFIRM_FRAMES);

  logic running, running_next;
  logic [1:0] stage, stage_next;
  logic have_origin, have_origin_next;
  logic signed [POS_W-1:0] origin_pos, origin_pos_next;
  logic signed [POS_W-1:0] extreme_pos, extreme_pos_next;
  logic push_negative, push_negative_next;
  logic [TOT_W-1:0] north_total, north_total_next;
  logic [TOT_W-1:0] south_total, south_total_next;
  logic [STREAK_W-1:0] move_streak, move_streak_next;
  logic [TOT_W-1:0] estimate_ms, estimate_ms_next;
  logic estimate_set, estimate_set_next;
  res_t res_next;

  logic take;
  logic signed [DIFF_W-1:0] cur, best, pulled;
  logic [DIFF_W-1:0] cur_abs, best_abs;
  logic ext_upd;
  logic signed [POS_W-1:0] ext_pos;
  logic ext_neg;
  logic [PMS_W-1:0] north_len, probe_len;
  logic [DIST_W-1:0] thr;

  assign frame_ready = !out_valid || !out_stall;
  assign take = frame_valid && frame_ready;

  assign north_len = (cfg.north_pulse_ms == '0) ? PMS_W'(1) : cfg.north_pulse_ms;
  assign probe_len = (cfg.probe_pulse_ms == '0) ? PMS_W'(1) : cfg.probe_pulse_ms;
  assign thr = (cfg.detect_move < MIN_DETECT) ? MIN_DETECT : cfg.detect_move;

  assign cur = {frame.pos[POS_W-1], frame.pos} - {origin_pos[POS_W-1], origin_pos};
  assign best = {extreme_pos[POS_W-1], extreme_pos} - {origin_pos[POS_W-1], origin_pos};
  assign cur_abs = cur[DIFF_W-1] ? DIFF_W'(-cur) : DIFF_W'(cur);
  assign best_abs = best[DIFF_W-1] ? DIFF_W'(-best) : DIFF_W'(best);

  // extreme after this frame
  assign ext_upd = cur_abs > best_abs;
  assign ext_pos = ext_upd ? frame.pos : extreme_pos;
  assign ext_neg = ext_upd ? cur[DIFF_W-1] : push_negative;
  assign pulled = ext_neg
    ? {frame.pos[POS_W-1], frame.pos} - {ext_pos[POS_W-1], ext_pos}
    : {ext_pos[POS_W-1], ext_pos} - {frame.pos[POS_W-1], frame.pos};

  always_comb begin
    running_next = running;
    stage_next = stage;
    have_origin_next = have_origin;
    origin_pos_next = origin_pos;
    extreme_pos_next = extreme_pos;
    push_negative_next = push_negative;
    north_total_next = north_total;
    south_total_next = south_total;
    move_streak_next = move_streak;
    estimate_ms_next = estimate_ms;
    estimate_set_next = estimate_set;
    res_next = '0;

    if (frame.cmd) begin
      running_next = 1'b1;
      stage_next = STAGE_NORTH;
      have_origin_next = 1'b0;
      origin_pos_next = '0;
      extreme_pos_next = '0;
      push_negative_next = 1'b0;
      north_total_next = '0;
      south_total_next = '0;
      move_streak_next = '0;
      estimate_ms_next = '0;
      estimate_set_next = 1'b0;
    end else if (running) begin
      if (!have_origin) begin
        have_origin_next = 1'b1;
        origin_pos_next = frame.pos;
        extreme_pos_next = frame.pos;
        push_negative_next = 1'b0;
      end else begin
        if (ext_upd) begin
          extreme_pos_next = ext_pos;
          push_negative_next = ext_neg;
        end
        unique case (stage)
          STAGE_NORTH: begin
            if (cur_abs >= {{(DIFF_W - DIST_W){1'b0}}, cfg.north_target}) begin
              stage_next = STAGE_SOUTH;
              move_streak_next = '0;
            end else if (cfg.north_limit_ms != '0 && north_total >= cfg.north_limit_ms) begin
              res_next.done_res = 1'b1;
              res_next.status = STATUS_NORTH_TIMEOUT;
              running_next = 1'b0;
            end else begin
              res_next.pulse_valid = 1'b1;
              res_next.pulse_dir = 1'b0;
              res_next.pulse_ms = north_len;
              north_total_next = sat_add(north_total, north_len);
            end
          end
          STAGE_SOUTH: begin
            if (south_total == '0) begin
              res_next.pulse_valid = 1'b1;
              res_next.pulse_dir = 1'b1;
              res_next.pulse_ms = probe_len;
              south_total_next = sat_add(south_total, probe_len);
            end else begin
              if (!pulled[DIFF_W-1] &&
                  pulled[DIFF_W-2:0] >= {{(DIFF_W - 1 - DIST_W){1'b0}}, thr}) begin
                if (move_streak != STREAK_MAX) begin
                  move_streak_next = move_streak + STREAK_W'(1);
                end
                if (move_streak_next == STREAK_W'(1) && !estimate_set) begin
                  estimate_ms_next = south_total;
                  estimate_set_next = 1'b1;
                end
              end else begin
                move_streak_next = '0;
              end
              if (move_streak_next >= CONFIRM) begin
                res_next.done_res = 1'b1;
                res_next.status = STATUS_OK;
                res_next.backlash_ms = estimate_set_next ? estimate_ms_next : south_total;
                running_next = 1'b0;
                stage_next = STAGE_DONE;
              end else if (cfg.probe_limit_ms != '0 && south_total >= cfg.probe_limit_ms) begin
                res_next.done_res = 1'b1;
                res_next.status = STATUS_SOUTH_TIMEOUT;
                running_next = 1'b0;
              end else begin
                res_next.pulse_valid = 1'b1;
                res_next.pulse_dir = 1'b1;
                res_next.pulse_ms = probe_len;
                south_total_next = sat_add(south_total, probe_len);
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      stage <= STAGE_NORTH;
      have_origin <= 1'b0;
      origin_pos <= '0;
      extreme_pos <= '0;
      push_negative <= 1'b0;
      north_total <= '0;
      south_total <= '0;
      move_streak <= '0;
      estimate_ms <= '0;
      estimate_set <= 1'b0;
    end else if (take) begin
      running <= running_next;
      stage <= stage_next;
      have_origin <= have_origin_next;
      origin_pos <= origin_pos_next;
      extreme_pos <= extreme_pos_next;
      push_negative <= push_negative_next;
      north_total <= north_total_next;
      south_total <= south_total_next;
      move_streak <= move_streak_next;
      estimate_ms <= estimate_ms_next;
      estimate_set <= estimate_set_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_ready) begin
      out_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule

[sv/dec_backlash_probe_sequencer_core.sv]
// Dec backlash probe sequencer. Write the eight setup registers while idle,
// then send a start word (cmd high) followed by one centroid word per frame.
// Every input word yields exactly one result word: a guide pulse request,
// a finished flag with status and backlash time, or nothing to do. The block
// takes one word per cycle while the output is not stalled; the multiply
// register loads on the taking edge, then the projection rounding register,
// then the sequencer loads the result register.
module dec_backlash_probe_sequencer_core #(
  parameter int CONFIRM_FRAMES = dbps_pkg::CONFIRM_FRAMES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wen,
  input  logic [dbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic cmd,
  input  logic [dbps_pkg::CEN_W-1:0] centroid_x,
  input  logic [dbps_pkg::CEN_W-1:0] centroid_y,
  output logic out_valid,
  input  logic out_stall,
  output logic pulse_valid,
  output logic pulse_dir,
  output logic [dbps_pkg::PMS_W-1:0] pulse_ms,
  output logic done_res,
  output logic [1:0] status,
  output logic [dbps_pkg::TOT_W-1:0] backlash_ms
);
  import dbps_pkg::*;

  cfg_t cfg;
  logic in_ready;
  logic frame_valid;
  logic frame_ready;
  frame_t frame;
  res_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dec_axis_x <= 16'sd0;
      cfg.dec_axis_y <= 16'sd16384;
      cfg.north_pulse_ms <= 16'd100;
      cfg.north_limit_ms <= '0;
      cfg.north_target <= '0;
      cfg.probe_pulse_ms <= 16'd100;
      cfg.probe_limit_ms <= '0;
      cfg.detect_move <= MIN_DETECT;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_AXIS_X:       cfg.dec_axis_x <= cfg_data[AXIS_W-1:0];
        CFG_AXIS_Y:       cfg.dec_axis_y <= cfg_data[AXIS_W-1:0];
        CFG_NORTH_PULSE:  cfg.north_pulse_ms <= cfg_data[PMS_W-1:0];
        CFG_NORTH_LIMIT:  cfg.north_limit_ms <= cfg_data[TOT_W-1:0];
        CFG_NORTH_TARGET: cfg.north_target <= cfg_data[DIST_W-1:0];
        CFG_PROBE_PULSE:  cfg.probe_pulse_ms <= cfg_data[PMS_W-1:0];
        CFG_PROBE_LIMIT:  cfg.probe_limit_ms <= cfg_data[TOT_W-1:0];
        CFG_DETECT_MOVE:  cfg.detect_move <= cfg_data[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !in_ready;

  dbps_proj u_proj (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .centroid_x  (centroid_x),
    .centroid_y  (centroid_y),
    .axis_x      (cfg.dec_axis_x),
    .axis_y      (cfg.dec_axis_y),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  dbps_ctrl #(
    .CONFIRM_FRAMES (CONFIRM_FRAMES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .res         (res)
  );

  assign pulse_valid = res.pulse_valid;
  assign pulse_dir = res.pulse_dir;
  assign pulse_ms = res.pulse_ms;
  assign done_res = res.done_res;
  assign status = res.status;
  assign backlash_ms = res.backlash_ms;

endmodule

[sv/dbps_check.sv]
module dbps_check (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic pulse_valid,
  input logic pulse_dir,
  input logic [dbps_pkg::PMS_W-1:0] pulse_ms,
  input logic done_res,
  input logic [1:0] status,
  input logic [dbps_pkg::TOT_W-1:0] backlash_ms
);
  import dbps_pkg::*;

  // held word stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pulse_ms) && $stable(backlash_ms)
      && $stable(status) && $stable(pulse_valid) && $stable(done_res) && $stable(pulse_dir))
    else $error("result word changed while stalled");

  // a pulse word carries a nonzero length, an idle word carries none
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pulse_valid ? (pulse_ms != '0)
                               : (pulse_ms == '0 && pulse_dir == 1'b0)))
    else $error("pulse fields inconsistent");

  // finishing and pulsing never share a word
  a_done_no_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !pulse_valid &&
      (status == STATUS_OK || status == STATUS_NORTH_TIMEOUT ||
       status == STATUS_SOUTH_TIMEOUT))
    else $error("done word with pulse or bad status");

  // status and backlash only show on a finished word
  a_result_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (!done_res || status != STATUS_OK) |->
      backlash_ms == '0 && (done_res || status == STATUS_OK))
    else $error("stray status or backlash");

endmodule

bind dec_backlash_probe_sequencer_core dbps_check u_dbps_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pulse_valid (pulse_valid),
  .pulse_dir   (pulse_dir),
  .pulse_ms    (pulse_ms),
  .done_res    (done_res),
  .status      (status),
  .backlash_ms (backlash_ms)
);

[sim/dbps_checker.sv]
module dbps_checker #(
  parameter int CONFIRM = dbps_pkg::CONFIRM_FRAMES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wen,
  input  logic [dbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  input  logic in_stall,
  input  logic cmd,
  input  logic [dbps_pkg::CEN_W-1:0] centroid_x,
  input  logic [dbps_pkg::CEN_W-1:0] centroid_y,
  input  logic out_valid,
  input  logic out_stall,
  input  logic pulse_valid,
  input  logic pulse_dir,
  input  logic [dbps_pkg::PMS_W-1:0] pulse_ms,
  input  logic done_res,
  input  logic [1:0] status,
  input  logic [dbps_pkg::TOT_W-1:0] backlash_ms,
  output int pend_cnt,
  output int fail_cnt
);
  import dbps_pkg::*;

  typedef enum logic [1:0] {STG_NORTH, STG_SOUTH, STG_DONE} stage_e;
  localparam logic DIR_NORTH = 1'b0;
  localparam logic DIR_SOUTH = 1'b1;

  logic signed [AXIS_W-1:0] axis_x, axis_y;
  logic [PMS_W-1:0] npulse, ppulse;
  logic [TOT_W-1:0] nlimit, plimit;
  logic [DIST_W-1:0] ntarget, detect;

  logic armed, origin_set, neg_push, est_valid;
  stage_e stage;
  int origin_pos, extreme_pos;
  logic [TOT_W-1:0] north_ms, south_ms, est_ms;
  logic [STREAK_W-1:0] streak;

  res_t guide_words_due[$];
  int fails = 0;

  function automatic void clear_run();
    armed = 1'b0;
    stage = STG_NORTH;
    origin_set = 1'b0;
    origin_pos = 0;
    extreme_pos = 0;
    neg_push = 1'b0;
    north_ms = '0;
    south_ms = '0;
    streak = '0;
    est_ms = '0;
    est_valid = 1'b0;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [TOT_W-1:0] total_add(logic [TOT_W-1:0] a, logic [PMS_W-1:0] b);
    logic [TOT_W:0] s;
    s = a + b;
    return (s > {1'b0, {TOT_W{1'b1}}}) ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

  // dec axis projection, rounded half up, 1/256 px
  function automatic int dec_project(logic [CEN_W-1:0] cx, logic [CEN_W-1:0] cy);
    longint acc;
    acc = longint'(cx) * longint'(axis_x) + longint'(cy) * longint'(axis_y);
    return int'((acc + 8192) >>> FRAC_W);
  endfunction

  function automatic res_t next_guide_word(logic c, logic [CEN_W-1:0] cx,
                                           logic [CEN_W-1:0] cy);
    res_t r;
    int pos;
    longint cur, best, pulled;
    logic [PMS_W-1:0] np, sp;
    logic [DIST_W-1:0] thr;
    r = '0;
    np = (npulse == 0) ? 1 : npulse;
    sp = (ppulse == 0) ? 1 : ppulse;
    thr = (detect < MIN_DETECT) ? MIN_DETECT : detect;
    if (c) begin
      clear_run();
      armed = 1'b1;
    end else if (armed) begin
      pos = dec_project(cx, cy);
      if (!origin_set) begin
        origin_set = 1'b1;
        origin_pos = pos;
        extreme_pos = pos;
        neg_push = 1'b0;
      end else begin
        cur = longint'(pos) - longint'(origin_pos);
        best = longint'(extreme_pos) - longint'(origin_pos);
        if (mag(cur) > mag(best)) begin
          extreme_pos = pos;
          neg_push = (cur < 0);
        end
        case (stage)
          STG_NORTH: begin
            if (mag(cur) >= longint'(ntarget)) begin
              stage = STG_SOUTH;
              streak = '0;
            end else if (nlimit != 0 && north_ms >= nlimit) begin
              r.done_res = 1'b1;
              r.status = STATUS_NORTH_TIMEOUT;
              armed = 1'b0;
            end else begin
              r.pulse_valid = 1'b1;
              r.pulse_dir = DIR_NORTH;
              r.pulse_ms = np;
              north_ms = total_add(north_ms, np);
            end
          end
          STG_SOUTH: begin
            if (south_ms == 0) begin
              r.pulse_valid = 1'b1;
              r.pulse_dir = DIR_SOUTH;
              r.pulse_ms = sp;
              south_ms = total_add(south_ms, sp);
            end else begin
              pulled = neg_push ? longint'(pos) - longint'(extreme_pos)
                                : longint'(extreme_pos) - longint'(pos);
              if (pulled >= longint'(thr)) begin
                if (streak != {STREAK_W{1'b1}}) streak = streak + 1'b1;
                if (streak == 1 && !est_valid) begin
                  est_ms = south_ms;
                  est_valid = 1'b1;
                end
              end else begin
                streak = '0;
              end
              if (streak >= CONFIRM) begin
                r.done_res = 1'b1;
                r.status = STATUS_OK;
                r.backlash_ms = est_valid ? est_ms : south_ms;
                armed = 1'b0;
                stage = STG_DONE;
              end else if (plimit != 0 && south_ms >= plimit) begin
                r.done_res = 1'b1;
                r.status = STATUS_SOUTH_TIMEOUT;
                armed = 1'b0;
              end else begin
                r.pulse_valid = 1'b1;
                r.pulse_dir = DIR_SOUTH;
                r.pulse_ms = sp;
                south_ms = total_add(south_ms, sp);
              end
            end
          end
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      axis_x = 0;
      axis_y = 16384;
      npulse = 100;
      nlimit = 0;
      ntarget = 0;
      ppulse = 100;
      plimit = 0;
      detect = 13;
      clear_run();
      guide_words_due.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_AXIS_X: axis_x = cfg_data[AXIS_W-1:0];
          CFG_AXIS_Y: axis_y = cfg_data[AXIS_W-1:0];
          CFG_NORTH_PULSE: npulse = cfg_data[PMS_W-1:0];
          CFG_NORTH_LIMIT: nlimit = cfg_data[TOT_W-1:0];
          CFG_NORTH_TARGET: ntarget = cfg_data[DIST_W-1:0];
          CFG_PROBE_PULSE: ppulse = cfg_data[PMS_W-1:0];
          CFG_PROBE_LIMIT: plimit = cfg_data[TOT_W-1:0];
          CFG_DETECT_MOVE: detect = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        guide_words_due.push_back(next_guide_word(cmd, centroid_x, centroid_y));
      if (out_valid && !out_stall) begin
        if (guide_words_due.size() == 0) begin
          $display("%0t: result word mismatch: expected none, actual pv=%0d dir=%0d ms=%0d",
                   $time, pulse_valid, pulse_dir, pulse_ms);
          $display("%0t:   actual done=%0d st=%0d bl=%0d",
                   $time, done_res, status, backlash_ms);
          fails++;
        end else begin
          want = guide_words_due.pop_front();
          check_field("pulse_valid", 32'(want.pulse_valid), 32'(pulse_valid));
          check_field("pulse_dir", 32'(want.pulse_dir), 32'(pulse_dir));
          check_field("pulse_ms", 32'(want.pulse_ms), 32'(pulse_ms));
          check_field("done_res", 32'(want.done_res), 32'(done_res));
          check_field("status", 32'(want.status), 32'(status));
          check_field("backlash_ms", 32'(want.backlash_ms), 32'(backlash_ms));
        end
      end
    end
    pend_cnt <= guide_words_due.size();
    fail_cnt <= fails;
  end

endmodule

[sim/testbench.sv]
module testbench;
  import dbps_pkg::*;

  localparam int RAND_WORDS = 1650;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic [CEN_W-1:0] centroid_x = '0;
  logic [CEN_W-1:0] centroid_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic pulse_valid, pulse_dir, done_res;
  logic [PMS_W-1:0] pulse_ms;
  logic [1:0] status;
  logic [TOT_W-1:0] backlash_ms;
  int pend_cnt, fail_cnt;

  always #1 clk = ~clk;

  dec_backlash_probe_sequencer_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .centroid_x(centroid_x), .centroid_y(centroid_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .pulse_valid(pulse_valid), .pulse_dir(pulse_dir), .pulse_ms(pulse_ms),
    .done_res(done_res), .status(status), .backlash_ms(backlash_ms)
  );

  dbps_checker u_chk (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .centroid_x(centroid_x), .centroid_y(centroid_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .pulse_valid(pulse_valid), .pulse_dir(pulse_dir), .pulse_ms(pulse_ms),
    .done_res(done_res), .status(status), .backlash_ms(backlash_ms),
    .pend_cnt(pend_cnt), .fail_cnt(fail_cnt)
  );

  // receiver: stall pattern plus one long hold-off
  int unsigned stall_mode = 0, mode_left = 0, hold_left = 0, stall_tick = 0;
  logic hold_armed = 1'b0;
  logic hold_taken = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      stall_tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= ((stall_tick % 8) < 5);
        endcase
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int words_sent = 0;
  int burst_left = 0;
  int ax_g = 0, ay_g = 16384, tgt_g = 0, thr_g = 13;
  longint bx = 0, by = 0;

  task automatic send_word(input logic c, input logic [CEN_W-1:0] x,
                           input logic [CEN_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd <= c;
    centroid_x <= x;
    centroid_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  function automatic logic [CEN_W-1:0] clamp_cen(longint v);
    if (v < 0) return '0;
    if (v > 1048575) return '1;
    return v[CEN_W-1:0];
  endfunction

  // frame displaced by d along the dec axis from the current base
  task automatic frame_at(input longint d);
    send_word(1'b0, clamp_cen(bx + (d * ax_g) / 16384), clamp_cen(by + (d * ay_g) / 16384));
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pad16(int v);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    return {junk, v[15:0]};
  endfunction

  task automatic write_setup(input int ax, input int ay, input int npl, input int nlim,
                             input int tgt, input int ppl, input int plim, input int det);
    logic signed [AXIS_W-1:0] a16;
    quiesce();
    write_reg(CFG_AXIS_X, pad16(ax));
    write_reg(CFG_AXIS_Y, pad16(ay));
    write_reg(CFG_NORTH_PULSE, pad16(npl));
    write_reg(CFG_NORTH_LIMIT, nlim[CFG_DATA_W-1:0]);
    write_reg(CFG_NORTH_TARGET, pad16(tgt));
    write_reg(CFG_PROBE_PULSE, pad16(ppl));
    write_reg(CFG_PROBE_LIMIT, plim[CFG_DATA_W-1:0]);
    write_reg(CFG_DETECT_MOVE, pad16(det));
    cfg_wen <= 1'b0;
    a16 = ax[15:0];
    ax_g = a16;
    a16 = ay[15:0];
    ay_g = a16;
    tgt_g = tgt & 16'hFFFF;
    thr_g = det & 16'hFFFF;
    if (thr_g < int'(MIN_DETECT)) thr_g = int'(MIN_DETECT);
  endtask

  function automatic int pick_pulse();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(1, 3000);
    endcase
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 7))
      0, 1, 2: return 0;
      3: return 1000000;
      4: return 1048575;
      default: return $urandom_range(1, 20000);
    endcase
  endfunction

  // start, origin, push out to the target, then pull back past the threshold
  task automatic run_measurement();
    longint d, ext, s, step;
    int k, n;
    send_word(1'b1, CEN_W'($urandom), CEN_W'($urandom));
    bx = $urandom_range(150000, 900000);
    by = $urandom_range(150000, 900000);
    s = ($urandom_range(0, 1) == 1) ? 1 : -1;
    d = 0;
    frame_at(d);
    k = 0;
    while (((d < 0) ? -d : d) < tgt_g + 2 && k < 24) begin
      step = $urandom_range(0, tgt_g / 4 + 40);
      if ($urandom_range(0, 9) == 0) step = -step / 2;
      d = d + s * step;
      frame_at(d);
      k++;
    end
    ext = d;
    n = $urandom_range(1, 4);
    repeat (n) begin
      step = $urandom_range(0, 2);
      frame_at(ext + s * step);
    end
    n = $urandom_range(3, 10);
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) step = thr_g + $urandom_range(0, 2 * thr_g);
      else step = $urandom_range(0, thr_g - 1);
      frame_at(ext - s * step);
    end
  endtask

  initial begin
    int ax, ay, n, phase;
    int dir_words;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset setup: idle frames, then a start and a run that keeps probing south
    send_word(1'b0, '0, '0);
    send_word(1'b0, '1, '1);
    send_word(1'b1, '0, '0);
    send_word(1'b0, '1, 20'd500000);
    send_word(1'b0, '1, 20'd500000);
    send_word(1'b0, '0, 20'd500000);
    repeat (3) send_word(1'b0, '0, 20'd499980);
    send_word(1'b0, '0, 20'd499980);

    // north total saturates, then hits the full-scale limit
    write_setup(0, 16384, 65535, 1048575, 65535, 0, 0, 0);
    send_word(1'b1, '0, '0);
    repeat (19) send_word(1'b0, '0, 20'd1000);
    dir_words = words_sent;

    phase = 0;
    while (words_sent < dir_words + RAND_WORDS) begin
      case ($urandom_range(0, 7))
        0: begin ax = 16384; ay = 0; end
        1: begin ax = -16384; ay = 0; end
        2: begin ax = 0; ay = 16384; end
        3: begin ax = 0; ay = -16384; end
        4: begin ax = 11585; ay = 11585; end
        5: begin ax = -11585; ay = 11585; end
        6: begin ax = 11585; ay = -11585; end
        default: begin ax = $urandom_range(0, 65535); ay = $urandom_range(0, 65535); end
      endcase
      write_setup(ax, ay, pick_pulse(), pick_limit(),
                  ($urandom_range(0, 7) == 0) ? 0 :
                  ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 3000),
                  pick_pulse(), pick_limit(),
                  ($urandom_range(0, 7) == 0) ? 0 :
                  ($urandom_range(0, 15) == 0) ? 65535 : $urandom_range(1, 200));
      if (phase == 1) hold_armed <= 1'b1;
      n = $urandom_range(3, 6);
      repeat (n) begin
        run_measurement();
        repeat ($urandom_range(0, 3))
          send_word(($urandom_range(0, 7) == 0), CEN_W'($urandom), CEN_W'($urandom));
      end
      phase++;
    end

    quiesce();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
